/* rtl/sps_pkg.sv */
// shared types and constants for the step pattern sample store
package sps_pkg;

  localparam int SLOT_COUNT    = 16;
  localparam int NUM_SAMPLES   = 16;
  localparam int SLOT_CAPACITY = 8;

  localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SAMPLE_W = $clog2(NUM_SAMPLES);
  localparam int IDX_W    = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
  localparam int FILL_W   = $clog2(SLOT_CAPACITY + 1);

  // entry memory is addressed as {slot, position}
  localparam int ENTRY_ADDR_W = SLOT_W + IDX_W;
  localparam int ENTRY_DEPTH  = 1 << ENTRY_ADDR_W;

  // fixed port widths
  localparam int CMD_W      = 3;
  localparam int IN_SLOT_W  = 8;
  localparam int IN_ID_W    = 8;
  localparam int COUNT_W    = 4;
  localparam int OUT_SMP_W  = 4;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    OP_ADD       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_QUERY     = 3'd3,
    OP_PLAY      = 3'd4,
    OP_PLAY_ON   = 3'd5,
    OP_PLAY_OFF  = 3'd6,
    OP_CLEAR_ALL = 3'd7
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] id;
    logic                slot_ok;
    logic                id_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t data;
  } cmdq_t;

endpackage

/* rtl/sps_ram.sv */
// generic single write port ram with registered read
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sps_front.sv */
// command intake: range checks and a short command queue
module sps_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [sps_pkg::CMD_W-1:0]      in_command,
  input  logic [sps_pkg::IN_SLOT_W-1:0]  in_slot,
  input  logic [sps_pkg::IN_ID_W-1:0]    in_sample_id,
  output sps_pkg::cmdq_t                 q_out,
  input  logic                           q_pop
);

  sps_pkg::cmd_t                      mem_r [sps_pkg::CMDQ_DEPTH];
  logic [sps_pkg::CMDQ_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sps_pkg::CMDQ_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sps_pkg::CMDQ_CNT_W-1:0]     cnt_r, cnt_nxt;
  sps_pkg::cmd_t                      cmd_in;
  logic                               do_push, do_pop;

  // classify the incoming beat
  always_comb begin
    cmd_in.op      = sps_pkg::op_t'(in_command);
    cmd_in.slot    = in_slot[sps_pkg::SLOT_W-1:0];
    cmd_in.id      = in_sample_id[sps_pkg::SAMPLE_W-1:0];
    cmd_in.slot_ok = {1'b0, in_slot} < (sps_pkg::IN_SLOT_W + 1)'(sps_pkg::SLOT_COUNT);
    cmd_in.id_ok   = {1'b0, in_sample_id} < (sps_pkg::IN_ID_W + 1)'(sps_pkg::NUM_SAMPLES);
  end

  assign full    = (cnt_r == sps_pkg::CMDQ_CNT_W'(sps_pkg::CMDQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = q_pop && (cnt_r != '0);

  assign q_out.valid = (cnt_r != '0);
  assign q_out.data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sps_pkg::CMDQ_PTR_W'(sps_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sps_pkg::CMDQ_PTR_W'(sps_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/sps_back.sv */
// command executor: slot fill counts, entry memory walk and result register
module sps_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sps_pkg::cmdq_t                q_in,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_found,
  output logic [sps_pkg::COUNT_W-1:0]   out_count,
  output logic [sps_pkg::OUT_SMP_W-1:0] out_sample,
  output logic                          out_sample_valid,
  output logic                          out_last
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ADD_WR,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLAY_RD,
    ST_PLAY_OUT,
    ST_RESULT
  } state_t;

  state_t                             state_r, state_nxt;
  sps_pkg::cmd_t                      cur_r, cur_nxt;
  logic [sps_pkg::FILL_W-1:0]         k_r, k_nxt;
  logic                               found_r, found_nxt;
  logic                               playing_r, playing_nxt;
  logic [sps_pkg::FILL_W-1:0]         fill_r   [sps_pkg::SLOT_COUNT];
  logic [sps_pkg::FILL_W-1:0]         fill_nxt [sps_pkg::SLOT_COUNT];

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_found_r, out_found_nxt;
  logic [sps_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic [sps_pkg::OUT_SMP_W-1:0]      out_sample_r, out_sample_nxt;
  logic                               out_sv_r, out_sv_nxt;
  logic                               out_last_r, out_last_nxt;

  logic                               ram_we, ram_re;
  logic [sps_pkg::IDX_W-1:0]          w_idx, r_idx;
  logic [sps_pkg::ENTRY_ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [sps_pkg::SAMPLE_W-1:0]       ram_wdata, ram_rdata;

  logic [sps_pkg::FILL_W-1:0]         fill_cur;
  logic [sps_pkg::FILL_W-1:0]         k_inc;
  logic                               k_last;
  logic                               shift_more;
  logic                               out_free;
  logic                               out_load;
  logic [7:0]                         smp_wide;

  assign fill_cur   = cur_r.slot_ok ? fill_r[cur_r.slot] : '0;
  assign k_inc      = sps_pkg::FILL_W'({1'b0, k_r} + 1'b1);
  assign k_last     = ({1'b0, k_r} + 1'b1) == {1'b0, fill_cur};
  assign shift_more = ({1'b0, k_r} + 2'd2) < {1'b0, fill_cur};
  assign out_free   = !out_valid_r || pop;
  assign smp_wide   = 8'(ram_rdata);

  assign ram_waddr  = {cur_r.slot, w_idx};
  assign ram_raddr  = {cur_r.slot, r_idx};

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    playing_nxt    = playing_r;
    fill_nxt       = fill_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    w_idx          = k_r[sps_pkg::IDX_W-1:0];
    r_idx          = k_r[sps_pkg::IDX_W-1:0];
    ram_wdata      = ram_rdata;
    out_load       = 1'b0;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_sample_nxt = out_sample_r;
    out_sv_nxt     = out_sv_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_in.valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_in.data;
          k_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        unique case (cur_r.op) inside
          sps_pkg::OP_ADD, sps_pkg::OP_REMOVE, sps_pkg::OP_QUERY: begin
            if (cur_r.slot_ok && cur_r.id_ok) begin
              if (fill_cur != '0) begin
                state_nxt = ST_SCAN_RD;
              end else if (cur_r.op == sps_pkg::OP_ADD) begin
                state_nxt = ST_ADD_WR;
              end else begin
                state_nxt = ST_RESULT;
              end
            end else begin
              state_nxt = ST_RESULT;
            end
          end
          sps_pkg::OP_CLEAR: begin
            if (cur_r.slot_ok) begin
              fill_nxt[cur_r.slot] = '0;
            end
            state_nxt = ST_RESULT;
          end
          sps_pkg::OP_PLAY: begin
            if (cur_r.slot_ok && playing_r && (fill_cur != '0)) begin
              state_nxt = ST_PLAY_RD;
            end else begin
              state_nxt = ST_RESULT;
            end
          end
          sps_pkg::OP_PLAY_ON: begin
            playing_nxt = 1'b1;
            state_nxt   = ST_RESULT;
          end
          sps_pkg::OP_PLAY_OFF: begin
            playing_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end
          default: begin
            fill_nxt  = '{default: '0};
            state_nxt = ST_RESULT;
          end
        endcase
      end

      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (ram_rdata == cur_r.id) begin
          if (cur_r.op == sps_pkg::OP_QUERY) begin
            found_nxt = 1'b1;
            state_nxt = ST_RESULT;
          end else if (cur_r.op == sps_pkg::OP_REMOVE) begin
            if (k_last) begin
              fill_nxt[cur_r.slot] = fill_cur - 1'b1;
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_SHIFT_RD;
            end
          end else begin
            // duplicate add
            state_nxt = ST_RESULT;
          end
        end else if (k_last) begin
          state_nxt = (cur_r.op == sps_pkg::OP_ADD) ? ST_ADD_WR : ST_RESULT;
        end else begin
          k_nxt     = k_inc;
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_ADD_WR: begin
        if (fill_cur < sps_pkg::FILL_W'(sps_pkg::SLOT_CAPACITY)) begin
          ram_we    = 1'b1;
          w_idx     = fill_cur[sps_pkg::IDX_W-1:0];
          ram_wdata = cur_r.id;
          fill_nxt[cur_r.slot] = fill_cur + 1'b1;
        end
        state_nxt = ST_RESULT;
      end

      ST_SHIFT_RD: begin
        ram_re    = 1'b1;
        r_idx     = k_inc[sps_pkg::IDX_W-1:0];
        state_nxt = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        ram_we = 1'b1;
        k_nxt  = k_inc;
        if (shift_more) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          fill_nxt[cur_r.slot] = fill_cur - 1'b1;
          state_nxt = ST_RESULT;
        end
      end

      ST_PLAY_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_PLAY_OUT;
      end

      ST_PLAY_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_found_nxt  = 1'b0;
          out_count_nxt  = sps_pkg::COUNT_W'(fill_cur);
          out_sample_nxt = smp_wide[sps_pkg::OUT_SMP_W-1:0];
          out_sv_nxt     = 1'b1;
          out_last_nxt   = k_last;
          if (k_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = ST_PLAY_RD;
          end
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_found_nxt  = found_r;
          out_count_nxt  = sps_pkg::COUNT_W'(fill_cur);
          out_sample_nxt = '0;
          out_sv_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_r        <= '0;
      k_r          <= '0;
      found_r      <= 1'b0;
      playing_r    <= 1'b0;
      fill_r       <= '{default: '0};
      out_valid_r  <= 1'b0;
      out_found_r  <= 1'b0;
      out_count_r  <= '0;
      out_sample_r <= '0;
      out_sv_r     <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      k_r          <= k_nxt;
      found_r      <= found_nxt;
      playing_r    <= playing_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      out_found_r  <= out_found_nxt;
      out_count_r  <= out_count_nxt;
      out_sample_r <= out_sample_nxt;
      out_sv_r     <= out_sv_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  sps_ram #(
    .WIDTH (sps_pkg::SAMPLE_W),
    .DEPTH (sps_pkg::ENTRY_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign empty            = !out_valid_r;
  assign out_found        = out_found_r;
  assign out_count        = out_count_r;
  assign out_sample       = out_sample_r;
  assign out_sample_valid = out_sv_r;
  assign out_last         = out_last_r;

  // entry memory is only written by an append or a shift step
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_ADD_WR || state_r == ST_SHIFT_WR))
    else $error("entry write outside append or shift");

  // a result never overwrites one that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || pop))
    else $error("result register overwritten");

  // the executor takes a new command only when it has finished the last one
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && q_in.valid))
    else $error("command taken while busy");

  // playback flag changes only while a command is being dispatched
  a_play_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (playing_r != $past(playing_r))) |-> ($past(state_r) == ST_DISPATCH))
    else $error("playback flag changed outside dispatch");

  // slot fill never exceeds the slot capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> (fill_cur <= sps_pkg::FILL_W'(sps_pkg::SLOT_CAPACITY)))
    else $error("slot fill above capacity");

endmodule

/* rtl/step_pattern_sample_store.sv */
// top level of the step pattern sample store: intake queue feeding the executor
// flow: a pushed beat is registered in the command queue and taken by the executor
//   once it is idle; a command passes dispatch, a read and compare per entry scanned,
//   a read and write per entry shifted, an append write, then the result state
// play: a read state and an output state per emitted beat; the output state waits
//   while the result register is unpopped; the entry memory has a single read port
// reset (synchronous, rst_n low): all slots empty, playback off, command queue and result register empty
module step_pattern_sample_store (
  input  logic                          clk,
  input  logic                          rst_n,
  // command side
  input  logic                          push,
  output logic                          full,
  input  logic [sps_pkg::CMD_W-1:0]     in_command,
  input  logic [sps_pkg::IN_SLOT_W-1:0] in_slot,
  input  logic [sps_pkg::IN_ID_W-1:0]   in_sample_id,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_found,
  output logic [sps_pkg::COUNT_W-1:0]   out_count,
  output logic [sps_pkg::OUT_SMP_W-1:0] out_sample,
  output logic                          out_sample_valid,
  output logic                          out_last
);

  // classified commands waiting for the executor
  sps_pkg::cmdq_t cmdq;
  logic           cmdq_pop;

  // front: range checks on slot and sample id, then a short command queue,
  // so a new beat is taken while the executor is still walking a slot
  sps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_command   (in_command),
    .in_slot      (in_slot),
    .in_sample_id (in_sample_id),
    .q_out        (cmdq),
    .q_pop        (cmdq_pop)
  );

  // back: holds the per-slot fill counts and playback flag, walks the entry
  // memory for search, append, shift-down removal and play, and drives the
  // result register that the consumer pops
  sps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_in             (cmdq),
    .q_pop            (cmdq_pop),
    .empty            (empty),
    .pop              (pop),
    .out_found        (out_found),
    .out_count        (out_count),
    .out_sample       (out_sample),
    .out_sample_valid (out_sample_valid),
    .out_last         (out_last)
  );

endmodule
